@@ hw/rtl/svg_pkg.sv @@
package svg_pkg;

    // Defaults of the top-level parameters
    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int PHASE_BITS_DEF   = 16;

    // Field and register widths
    localparam int IDX_W     = 8;
    localparam int RADIUS_W  = 25;
    localparam int SEG_W     = 9;
    localparam int STEP_W    = 16;
    localparam int COORD_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Internal widths
    localparam int TRIG_W = 17;              // Q16 magnitude 0..65536
    localparam int PH_W   = 18;              // quadrant (2) + fraction (16)
    localparam int RMAG_W = RADIUS_W;        // |radius| up to 2^24
    localparam int POS_W  = RMAG_W + 1;      // signed coordinate before centre add

    // Quarter-wave sine polynomial coefficients, Q16
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42047;
    localparam logic [12:0] SIN_C = 13'd4640;
    localparam logic [16:0] Q16_ONE = 17'd65536;

    // Pipeline depths
    localparam int FRONT_LAT = 1;
    localparam int TRIG_LAT  = 4;
    localparam int SCALE_LAT = 3;
    localparam int TOTAL_LAT = FRONT_LAT + TRIG_LAT + SCALE_LAT;

    // Register reset values
    localparam logic [RMAG_W-1:0]  RADIUS_MAG_RST = 25'd65536;
    localparam logic [SEG_W-1:0]   SEGMENTS_RST   = 9'd16;
    localparam logic [STEP_W-1:0]  PHASE_STEP_RST = 16'd4096;
    localparam logic [COORD_W-1:0] CENTRE_RST     = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS     = 3'd0,
        CFG_SEGMENTS   = 3'd1,
        CFG_PHASE_STEP = 3'd2,
        CFG_CENTRE_X   = 3'd3,
        CFG_CENTRE_Y   = 3'd4,
        CFG_CENTRE_Z   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [IDX_W-1:0] ring_index;
        logic [IDX_W-1:0] segment_index;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      vertex_ok;
    } t_out_item;

    typedef struct packed {
        logic ok;
        logic pole_n;
        logic pole_s;
    } t_ctrl;

    typedef struct packed {
        logic              neg;
        logic [TRIG_W-1:0] mag;
    } t_trig;

endpackage

@@ hw/rtl/svg_front.sv @@
module svg_front #(
    parameter int MAX_SEGMENTS = svg_pkg::MAX_SEGMENTS_DEF,
    parameter int PHASE_BITS   = svg_pkg::PHASE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  svg_pkg::t_in_item             i_item,
    input  logic [svg_pkg::SEG_W-1:0]     i_segments,
    input  logic [svg_pkg::STEP_W-1:0]    i_phase_step,
    output svg_pkg::t_ctrl                o_ctrl,
    output logic [svg_pkg::PH_W-1:0]      o_ph_a,
    output logic [svg_pkg::PH_W-1:0]      o_ph_b
);
    import svg_pkg::*;

    localparam int PROD_W = IDX_W + STEP_W;

    logic [PROD_W-1:0] w_prod_a;
    logic [PROD_W-1:0] w_prod_b;
    logic [31:0]       w_p32_a;
    logic [31:0]       w_p32_b;
    logic [IDX_W-1:0]  w_half;
    logic              w_bad_n;
    logic              w_bad_idx;
    t_ctrl             n_ctrl;
    t_ctrl             r_ctrl;
    logic [PH_W-1:0]   r_ph_a;
    logic [PH_W-1:0]   r_ph_b;

    // Phase wraps at PHASE_BITS, then sits at the top of a 32-bit turn
    assign w_prod_a = PROD_W'(i_item.ring_index) * PROD_W'(i_phase_step);
    assign w_prod_b = PROD_W'(i_item.segment_index) * PROD_W'(i_phase_step);
    assign w_p32_a  = {w_prod_a[PHASE_BITS-1:0], {(32-PHASE_BITS){1'b0}}};
    assign w_p32_b  = {w_prod_b[PHASE_BITS-1:0], {(32-PHASE_BITS){1'b0}}};

    assign w_half    = i_segments[SEG_W-1:1];
    assign w_bad_n   = (i_segments < SEG_W'(3)) || i_segments[0]
                       || (int'(i_segments) > MAX_SEGMENTS);
    assign w_bad_idx = (i_item.ring_index > w_half)
                       || ({1'b0, i_item.segment_index} >= i_segments);

    always_comb begin
        n_ctrl.ok     = !(w_bad_n || w_bad_idx);
        n_ctrl.pole_n = (i_item.ring_index == '0);
        n_ctrl.pole_s = (i_item.ring_index == w_half);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctrl <= n_ctrl;
            r_ph_a <= w_p32_a[31:32-PH_W];
            r_ph_b <= w_p32_b[31:32-PH_W];
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_ph_a = r_ph_a;
    assign o_ph_b = r_ph_b;

endmodule

@@ hw/rtl/svg_trig.sv @@
module svg_trig (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [svg_pkg::PH_W-1:0]  i_ph,
    output svg_pkg::t_trig            o_trig
);
    import svg_pkg::*;

    logic [15:0]       w_f;
    logic [TRIG_W-1:0] w_x;
    logic [33:0]       w_m1;
    logic [29:0]       w_m2;
    logic [32:0]       w_m3;
    logic [33:0]       w_m4;
    logic [17:0]       w_s;
    t_trig             n_trig;

    logic              r_s1_neg;
    logic [TRIG_W-1:0] r_s1_x;
    logic [TRIG_W-1:0] r_s1_x2;
    logic              r_s2_neg;
    logic [TRIG_W-1:0] r_s2_x;
    logic [TRIG_W-1:0] r_s2_x2;
    logic [15:0]       r_s2_t1;
    logic              r_s3_neg;
    logic [TRIG_W-1:0] r_s3_x;
    logic [16:0]       r_s3_t2;
    t_trig             r_s4_trig;

    // Mirror the fraction in odd quadrants
    assign w_f  = i_ph[15:0];
    assign w_x  = i_ph[16] ? (Q16_ONE - {1'b0, w_f}) : {1'b0, w_f};
    assign w_m1 = 34'(w_x) * 34'(w_x);

    assign w_m2 = 30'(r_s1_x2) * 30'(SIN_C);
    assign w_m3 = 33'(r_s2_x2) * 33'(r_s2_t1);
    assign w_m4 = 34'(r_s3_x) * 34'(r_s3_t2);
    assign w_s  = 18'((w_m4 + 34'd32768) >> 16);

    always_comb begin
        n_trig.neg = r_s3_neg;
        n_trig.mag = (w_s > 18'(Q16_ONE)) ? Q16_ONE : w_s[TRIG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_neg  <= i_ph[17];
            r_s1_x    <= w_x;
            r_s1_x2   <= TRIG_W'((w_m1 + 34'd32768) >> 16);
            r_s2_neg  <= r_s1_neg;
            r_s2_x    <= r_s1_x;
            r_s2_x2   <= r_s1_x2;
            r_s2_t1   <= SIN_B - 16'((w_m2 + 30'd32768) >> 16);
            r_s3_neg  <= r_s2_neg;
            r_s3_x    <= r_s2_x;
            r_s3_t2   <= SIN_A - 17'((w_m3 + 33'd32768) >> 16);
            r_s4_trig <= n_trig;
        end
    end

    assign o_trig = r_s4_trig;

endmodule

@@ hw/rtl/svg_scale.sv @@
module svg_scale (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  svg_pkg::t_ctrl                     i_ctrl,
    input  svg_pkg::t_trig                     i_sin_a,
    input  svg_pkg::t_trig                     i_cos_a,
    input  svg_pkg::t_trig                     i_sin_b,
    input  svg_pkg::t_trig                     i_cos_b,
    input  logic [svg_pkg::RMAG_W-1:0]         i_rad_mag,
    input  logic signed [svg_pkg::COORD_W-1:0] i_centre_x,
    input  logic signed [svg_pkg::COORD_W-1:0] i_centre_y,
    input  logic signed [svg_pkg::COORD_W-1:0] i_centre_z,
    output svg_pkg::t_out_item                 o_item
);
    import svg_pkg::*;

    localparam int MP_W  = RMAG_W + TRIG_W;
    localparam int SUM_W = COORD_W + 1;

    function automatic logic signed [POS_W-1:0] f_apply_sign(
        input logic [RMAG_W-1:0] mag,
        input logic              neg
    );
        logic signed [POS_W-1:0] v;
        v = signed'({1'b0, mag});
        return neg ? -v : v;
    endfunction

    function automatic logic signed [COORD_W-1:0] f_add_sat(
        input logic signed [POS_W-1:0]   v,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(v) + SUM_W'(c);
        if (s[SUM_W-1] != s[SUM_W-2]) begin
            return s[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return s[COORD_W-1:0];
    endfunction

    logic [MP_W-1:0]         w_xp;
    logic [MP_W-1:0]         w_ap;
    logic [MP_W-1:0]         w_yp;
    logic [MP_W-1:0]         w_zp;
    logic [RMAG_W-1:0]       w_ym;
    logic [RMAG_W-1:0]       w_zm;
    logic signed [POS_W-1:0] w_rad;
    logic signed [POS_W-1:0] n_px;
    logic signed [POS_W-1:0] n_py;
    logic signed [POS_W-1:0] n_pz;
    t_out_item               n_item;

    t_ctrl                   r_a_ctrl;
    logic [RMAG_W-1:0]       r_a_xm;
    logic                    r_a_xneg;
    logic [RMAG_W-1:0]       r_a_am;
    logic                    r_a_aneg;
    t_trig                   r_a_sb;
    t_trig                   r_a_cb;
    logic                    r_b_ok;
    logic signed [POS_W-1:0] r_b_px;
    logic signed [POS_W-1:0] r_b_py;
    logic signed [POS_W-1:0] r_b_pz;
    t_out_item               r_c_item;

    // Magnitudes round half up, which is half away from zero once signed
    assign w_xp = MP_W'(i_rad_mag) * MP_W'(i_cos_a.mag);
    assign w_ap = MP_W'(i_rad_mag) * MP_W'(i_sin_a.mag);
    assign w_yp = MP_W'(r_a_am) * MP_W'(r_a_sb.mag);
    assign w_zp = MP_W'(r_a_am) * MP_W'(r_a_cb.mag);
    assign w_ym = RMAG_W'((w_yp + MP_W'(32768)) >> 16);
    assign w_zm = RMAG_W'((w_zp + MP_W'(32768)) >> 16);
    assign w_rad = signed'({1'b0, i_rad_mag});

    always_comb begin
        if (r_a_ctrl.pole_n) begin
            n_px = w_rad;
            n_py = '0;
            n_pz = '0;
        end else if (r_a_ctrl.pole_s) begin
            n_px = -w_rad;
            n_py = '0;
            n_pz = '0;
        end else begin
            n_px = f_apply_sign(r_a_xm, r_a_xneg);
            n_py = f_apply_sign(w_ym, r_a_aneg ^ r_a_sb.neg);
            n_pz = f_apply_sign(w_zm, r_a_aneg ^ r_a_cb.neg);
        end
    end

    always_comb begin
        if (r_b_ok) begin
            n_item.pos_x     = f_add_sat(r_b_px, i_centre_x);
            n_item.pos_y     = f_add_sat(r_b_py, i_centre_y);
            n_item.pos_z     = f_add_sat(r_b_pz, i_centre_z);
            n_item.vertex_ok = 1'b1;
        end else begin
            n_item = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ctrl <= i_ctrl;
            r_a_xm   <= RMAG_W'((w_xp + MP_W'(32768)) >> 16);
            r_a_xneg <= i_cos_a.neg;
            r_a_am   <= RMAG_W'((w_ap + MP_W'(32768)) >> 16);
            r_a_aneg <= i_sin_a.neg;
            r_a_sb   <= i_sin_b;
            r_a_cb   <= i_cos_b;
            r_b_ok   <= r_a_ctrl.ok;
            r_b_px   <= n_px;
            r_b_py   <= n_py;
            r_b_pz   <= n_pz;
            r_c_item <= n_item;
        end
    end

    assign o_item = r_c_item;

endmodule

@@ hw/rtl/sphere_vertex_generator_unit.sv @@
// Channel  Direction  Handshake                   Payload
// input    in         i_in_valid / o_in_stall     i_in_data   (ring_index, segment_index)
// output   out        o_out_valid / i_out_stall   o_out_data  (pos_x, pos_y, pos_z, vertex_ok)
// config   in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// One vertex per cycle while the output transfer is not stalled.
// The depth is set by the four-multiply sine polynomial (4 stages), one phase
// stage and three stages for the radius products and centre add.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stalled output transfer freezes every stage and raises o_in_stall in the same cycle.
module sphere_vertex_generator_unit #(
    parameter int MAX_SEGMENTS = svg_pkg::MAX_SEGMENTS_DEF,
    parameter int PHASE_BITS   = svg_pkg::PHASE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  svg_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output svg_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [svg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [svg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import svg_pkg::*;

    logic [RMAG_W-1:0]         r_rad_mag;
    logic [SEG_W-1:0]          r_segments;
    logic [STEP_W-1:0]         r_phase_step;
    logic signed [COORD_W-1:0] r_centre_x;
    logic signed [COORD_W-1:0] r_centre_y;
    logic signed [COORD_W-1:0] r_centre_z;
    logic [RADIUS_W-1:0]       w_radius;
    logic [RMAG_W-1:0]         n_rad_mag;

    logic [TOTAL_LAT-1:0]      r_vld;
    logic                      w_en;
    t_ctrl                     w_ctrl;
    t_ctrl                     r_ctrl_dly [TRIG_LAT];
    logic [PH_W-1:0]           w_ph_a;
    logic [PH_W-1:0]           w_ph_b;
    logic [PH_W-1:0]           w_cph_a;
    logic [PH_W-1:0]           w_cph_b;
    t_trig                     w_sin_a;
    t_trig                     w_cos_a;
    t_trig                     w_sin_b;
    t_trig                     w_cos_b;

    // Only |radius| is ever used, so keep the magnitude
    assign w_radius  = i_cfg_data[RADIUS_W-1:0];
    assign n_rad_mag = w_radius[RADIUS_W-1] ? RMAG_W'(-w_radius) : w_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad_mag    <= RADIUS_MAG_RST;
            r_segments   <= SEGMENTS_RST;
            r_phase_step <= PHASE_STEP_RST;
            r_centre_x   <= CENTRE_RST;
            r_centre_y   <= CENTRE_RST;
            r_centre_z   <= CENTRE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS:     r_rad_mag    <= n_rad_mag;
                CFG_SEGMENTS:   r_segments   <= i_cfg_data[SEG_W-1:0];
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data[STEP_W-1:0];
                CFG_CENTRE_X:   r_centre_x   <= i_cfg_data[COORD_W-1:0];
                CFG_CENTRE_Y:   r_centre_y   <= i_cfg_data[COORD_W-1:0];
                CFG_CENTRE_Z:   r_centre_z   <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold every stage while the output transfer is stalled
    assign w_en       = !(r_vld[TOTAL_LAT-1] && i_out_stall);
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_in_valid};
        end
    end

    svg_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .PHASE_BITS   (PHASE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_en         (w_en),
        .i_item       (i_in_data),
        .i_segments   (r_segments),
        .i_phase_step (r_phase_step),
        .o_ctrl       (w_ctrl),
        .o_ph_a       (w_ph_a),
        .o_ph_b       (w_ph_b)
    );

    // Cosine is the sine a quarter turn ahead
    assign w_cph_a = {w_ph_a[PH_W-1:PH_W-2] + 2'd1, w_ph_a[PH_W-3:0]};
    assign w_cph_b = {w_ph_b[PH_W-1:PH_W-2] + 2'd1, w_ph_b[PH_W-3:0]};

    svg_trig u_sin_a (.i_clk(i_clk), .i_en(w_en), .i_ph(w_ph_a),  .o_trig(w_sin_a));
    svg_trig u_cos_a (.i_clk(i_clk), .i_en(w_en), .i_ph(w_cph_a), .o_trig(w_cos_a));
    svg_trig u_sin_b (.i_clk(i_clk), .i_en(w_en), .i_ph(w_ph_b),  .o_trig(w_sin_b));
    svg_trig u_cos_b (.i_clk(i_clk), .i_en(w_en), .i_ph(w_cph_b), .o_trig(w_cos_b));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctrl_dly[0] <= w_ctrl;
            for (int i = 1; i < TRIG_LAT; i++) begin
                r_ctrl_dly[i] <= r_ctrl_dly[i-1];
            end
        end
    end

    svg_scale u_scale (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_ctrl     (r_ctrl_dly[TRIG_LAT-1]),
        .i_sin_a    (w_sin_a),
        .i_cos_a    (w_cos_a),
        .i_sin_b    (w_sin_b),
        .i_cos_b    (w_cos_b),
        .i_rad_mag  (r_rad_mag),
        .i_centre_x (r_centre_x),
        .i_centre_y (r_centre_y),
        .i_centre_z (r_centre_z),
        .o_item     (o_out_data)
    );

    assign o_out_valid = r_vld[TOTAL_LAT-1];

endmodule

@@ hw/rtl/svg_check.sv @@
module svg_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input svg_pkg::t_out_item             o_out_data
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // The input side stalls exactly when the output transfer is stalled
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow output stall");

    // A rejected vertex carries a zero position
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.vertex_ok) |->
            (o_out_data.pos_x == '0 && o_out_data.pos_y == '0 && o_out_data.pos_z == '0))
        else $error("invalid vertex with nonzero position");

endmodule

bind sphere_vertex_generator_unit svg_check u_svg_check (.*);
